FILE: rtl/core/tcspq_pkg.sv
// Shared types and constants for the three-class stable priority queue.
// Holds the sizing constants, the status and request codes, the controller
// state type and the command struct. Depends on nothing.
package tcspq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 32;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam int CLASS_BITS  = 2;
  localparam int OCC_BITS    = 5;
  localparam int SENT_BITS   = 32;

  typedef logic [CLASS_BITS-1:0] class_t;
  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam class_t CLASS_INSTANT  = 2'd0;
  localparam class_t CLASS_STANDARD = 2'd1;
  localparam class_t CLASS_ECONOMY  = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEND   = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_SENT     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

FILE: rtl/core/tcspq_if.sv
// Channel interfaces for the request and response sides of the queue.
// Depends on tcspq_pkg for nothing but keeps the field widths of the block.
interface tcspq_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [1:0]  service_class;
  logic [31:0] package_tag;

  modport source (output valid, req_type, service_class, package_tag, input ready);
  modport sink (input valid, req_type, service_class, package_tag, output ready);
endinterface

interface tcspq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] sent_tag;
  logic [1:0]  sent_class;
  logic [4:0]  occupancy;

  modport source (output valid, status, sent_tag, sent_class, occupancy, input ready);
  modport sink (input valid, status, sent_tag, sent_class, occupancy, output ready);
endinterface

FILE: rtl/core/tcspq_ctrl.sv
// Controller of the queue: accepts one request, then runs it once the
// response register is free. Depends on tcspq_pkg.
module tcspq_ctrl
  import tcspq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        rsp_valid_next;
  logic        slot_free;

  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_EXEC: begin
        cmd.execute = slot_free;
      end
      default: ;
    endcase
  end

  // The response register holds its beat until the sink takes it.
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.execute) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: rtl/core/tcspq_dp.sv
// Datapath of the queue: request register, a chain of sorted cells with an
// entry count, and the response register. Depends on tcspq_pkg.
module tcspq_dp
  import tcspq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic        req_type,
  input  logic [1:0]  service_class,
  input  logic [31:0] package_tag,
  output logic [1:0]  status,
  output logic [31:0] sent_tag,
  output logic [1:0]  sent_class,
  output logic [4:0]  occupancy
);

  logic   type_q;
  class_t class_q;
  tag_t   tag_q;

  tag_t   tags    [QUEUE_DEPTH];
  class_t classes [QUEUE_DEPTH];
  count_t count, count_next;

  logic [QUEUE_DEPTH-1:0] below;
  logic    is_full, is_empty, do_insert, do_send;
  status_t status_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_q  <= req_type;
      // Class code three is served as economy.
      class_q <= (service_class > CLASS_ECONOMY) ? CLASS_ECONOMY : service_class;
      tag_q   <= TAG_BITS'(package_tag);
    end
  end

  assign is_full   = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign is_empty  = (count == '0);
  assign do_insert = cmd.execute && (type_q == REQ_INSERT) && !is_full;
  assign do_send   = cmd.execute && (type_q == REQ_SEND) && !is_empty;

  // Held cells are sorted by class, so the cells that stay in front of a new
  // entry form a prefix of the chain.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      below[i] = (COUNT_BITS'(i) < count) && (classes[i] <= class_q);
    end
  end

  always_comb begin
    count_next  = count;
    status_next = STAT_INSERTED;
    if (type_q == REQ_INSERT) begin
      if (is_full) status_next = STAT_FULL;
      else count_next = count + 1'b1;
    end else begin
      if (is_empty) begin
        status_next = STAT_EMPTY;
      end else begin
        status_next = STAT_SENT;
        count_next  = count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_insert && !below[i]) begin
        if (i == 0 || below[(i > 0) ? i - 1 : 0]) begin
          tags[i]    <= tag_q;
          classes[i] <= class_q;
        end else begin
          tags[i]    <= tags[(i > 0) ? i - 1 : 0];
          classes[i] <= classes[(i > 0) ? i - 1 : 0];
        end
      end else if (do_send && i < QUEUE_DEPTH - 1) begin
        tags[i]    <= tags[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        classes[i] <= classes[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status    <= status_next;
      occupancy <= OCC_BITS'(count_next);
      if (status_next == STAT_SENT) begin
        sent_tag   <= SENT_BITS'(tags[0]);
        sent_class <= classes[0];
      end else begin
        sent_tag   <= '0;
        sent_class <= CLASS_INSTANT;
      end
    end
  end

endmodule

FILE: rtl/core/three_class_stable_priority_queue_top.sv
// Top level of the three-class stable priority queue.
// Depends on tcspq_pkg, tcspq_if, tcspq_ctrl and tcspq_dp.
//
//   channel  direction  payload
//   req      in         req_type, service_class, package_tag
//   rsp      out        status, sent_tag, sent_class, occupancy
//
// Each request beat is first registered; then the whole cell chain compares
// and shifts and the response is loaded.
// A new request is taken while a response still waits in its register; the
// request then holds until the sink frees that register.
// Reset clears the controller and the entry count; cell contents are left as
// they are and never read until written.
module three_class_stable_priority_queue_top
  import tcspq_pkg::*;
(
  input logic         clk,
  input logic         rst,
  tcspq_req_if.sink   req,
  tcspq_rsp_if.source rsp
);

  dp_cmd_t cmd;

  tcspq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  tcspq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req.req_type),
    .service_class (req.service_class),
    .package_tag   (req.package_tag),
    .status        (rsp.status),
    .sent_tag      (rsp.sent_tag),
    .sent_class    (rsp.sent_class),
    .occupancy     (rsp.occupancy)
  );

endmodule

FILE: sim/three_class_stable_priority_queue_top_tb.sv
// Self-checking testbench for the three-class stable priority queue top level.
// Drives request beats through tcspq_req_if, checks response beats on tcspq_rsp_if
// against a cycle-free queue predictor. Depends on tcspq_pkg and tcspq_if.
module three_class_stable_priority_queue_top_tb;
  import tcspq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam class_t CLASS_SPARE    = 2'd3;
  localparam int     DIRECTED_FILL  = 11;
  localparam int     RAND_PER_PHASE = 432;
  localparam int     IDLE_LIMIT     = 5000;
  localparam int     SETTLE_CYCLES  = 20;

  typedef struct packed {
    status_t              status;
    logic [SENT_BITS-1:0] sent_tag;
    class_t               sent_class;
    logic [OCC_BITS-1:0]  occupancy;
  } outcome_t;

  typedef struct {
    logic        req_type;
    class_t      service_class;
    logic [31:0] package_tag;
    int          gap_pct;
    int          stall_pct;
    bit          drain_first;
  } request_item_t;

  logic clk;
  logic rst;

  tcspq_req_if req_ch ();
  tcspq_rsp_if rsp_ch ();

  three_class_stable_priority_queue_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predictor state: entries in service order.
  tag_t   shelf_tag   [QUEUE_DEPTH];
  class_t shelf_class [QUEUE_DEPTH];
  int     shelf_count;

  request_item_t pending_requests[$];
  outcome_t      expected_outcomes[$];

  int  mismatches;
  int  idle_cycles;
  int  rsp_stall_pct;
  bit  req_taken;
  int  n_inserted, n_sent, n_empty, n_full, peak_occupancy;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic outcome_t service_request(input logic rtype, input class_t cls,
                                               input logic [31:0] raw_tag);
    outcome_t res;
    int       pos;
    int       i;
    class_t   eff_cls;
    res = '{status: STAT_INSERTED, sent_tag: '0, sent_class: CLASS_INSTANT, occupancy: '0};
    if (rtype == REQ_INSERT) begin
      eff_cls = (cls == CLASS_SPARE) ? CLASS_ECONOMY : cls;
      if (shelf_count >= QUEUE_DEPTH) begin
        res.status = STAT_FULL;
        n_full++;
      end else begin
        pos = 0;
        while (pos < shelf_count && shelf_class[pos] <= eff_cls) pos++;
        for (i = shelf_count; i > pos; i--) begin
          shelf_tag[i]   = shelf_tag[i-1];
          shelf_class[i] = shelf_class[i-1];
        end
        shelf_tag[pos]   = tag_t'(raw_tag);
        shelf_class[pos] = eff_cls;
        shelf_count++;
        n_inserted++;
      end
    end else begin
      if (shelf_count == 0) begin
        res.status = STAT_EMPTY;
        n_empty++;
      end else begin
        res.status     = STAT_SENT;
        res.sent_tag   = SENT_BITS'(shelf_tag[0]);
        res.sent_class = shelf_class[0];
        for (i = 1; i < shelf_count; i++) begin
          shelf_tag[i-1]   = shelf_tag[i];
          shelf_class[i-1] = shelf_class[i];
        end
        shelf_count--;
        n_sent++;
      end
    end
    if (shelf_count > peak_occupancy) peak_occupancy = shelf_count;
    res.occupancy = OCC_BITS'(shelf_count);
    return res;
  endfunction

  task automatic add_request(input logic rtype, input class_t cls, input logic [31:0] tag,
                             input int gap, input int stall, input bit drain);
    request_item_t item;
    item = '{req_type: rtype, service_class: cls, package_tag: tag,
             gap_pct: gap, stall_pct: stall, drain_first: drain};
    pending_requests.push_back(item);
  endtask

  // Driver: a held request stays put until its beat is taken.
  always @(negedge clk) begin
    logic          next_valid;
    request_item_t item;
    if (!rst) begin
      if (!req_ch.valid || req_taken) begin
        next_valid = 1'b0;
        if (pending_requests.size() != 0) begin
          if (!(pending_requests[0].drain_first && expected_outcomes.size() != 0) &&
              $urandom_range(99) >= pending_requests[0].gap_pct) begin
            item = pending_requests.pop_front();
            next_valid = 1'b1;
            req_ch.req_type      <= item.req_type;
            req_ch.service_class <= item.service_class;
            req_ch.package_tag   <= item.package_tag;
            rsp_stall_pct = item.stall_pct;
          end
        end
        req_ch.valid <= next_valid;
        req_taken = 1'b0;
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Monitor: check the response beat first, then predict the request beat.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (rsp_ch.valid && rsp_ch.ready) begin
        idle_cycles = 0;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("response beat with nothing pending", 64'(rsp_ch.status), '0);
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
          if (rsp_ch.sent_tag !== want.sent_tag)
            report_mismatch("sent_tag", 64'(rsp_ch.sent_tag), 64'(want.sent_tag));
          if (rsp_ch.sent_class !== want.sent_class)
            report_mismatch("sent_class", 64'(rsp_ch.sent_class), 64'(want.sent_class));
          if (rsp_ch.occupancy !== want.occupancy)
            report_mismatch("occupancy", 64'(rsp_ch.occupancy), 64'(want.occupancy));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        idle_cycles = 0;
        req_taken = 1'b1;
        expected_outcomes.push_back(service_request(req_ch.req_type, req_ch.service_class,
                                                    req_ch.package_tag));
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int gap_by_phase   [4];
    int stall_by_phase [4];
    int ph, made, burst, bias, k;

    gap_by_phase   = '{0, 46, 0, 32};
    stall_by_phase = '{0, 0, 46, 32};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.service_class = CLASS_INSTANT;
    req_ch.package_tag = '0;
    rsp_ch.ready = 1'b0;
    rsp_stall_pct = 0;
    req_taken = 1'b0;
    idle_cycles = 0;
    mismatches = 0;
    shelf_count = 0;
    n_inserted = 0; n_sent = 0; n_empty = 0; n_full = 0; peak_occupancy = 0;

    // Directed part: empty send, spare class code, stable ordering, fill to full.
    add_request(REQ_SEND, CLASS_INSTANT, 32'h0, 0, 0, 1'b0);
    add_request(REQ_INSERT, CLASS_SPARE, 32'hFFFF_FFFF, 0, 0, 1'b0);
    add_request(REQ_INSERT, CLASS_INSTANT, 32'h0, 0, 0, 1'b0);
    add_request(REQ_INSERT, CLASS_STANDARD, 32'h5555_5555, 0, 0, 1'b0);
    add_request(REQ_INSERT, CLASS_INSTANT, 32'hAAAA_AAAA, 0, 0, 1'b0);
    add_request(REQ_INSERT, CLASS_ECONOMY, 32'h1, 0, 0, 1'b0);
    for (k = 0; k < DIRECTED_FILL; k++)
      add_request(REQ_INSERT, class_t'($urandom_range(3)), $urandom(), 0, 0, 1'b0);
    add_request(REQ_INSERT, CLASS_INSTANT, 32'h8000_0000, 0, 0, 1'b0);
    add_request(REQ_SEND, CLASS_SPARE, 32'hFFFF_FFFF, 0, 0, 1'b0);
    add_request(REQ_INSERT, CLASS_STANDARD, 32'h7FFF_FFFF, 0, 0, 1'b0);
    for (k = 0; k < 5; k++)
      add_request(REQ_SEND, class_t'($urandom_range(3)), $urandom(), 0, 0, 1'b0);

    // Random part: bursts lean toward inserts or sends so full and empty recur.
    for (ph = 0; ph < 4; ph++) begin
      made = 0;
      while (made < RAND_PER_PHASE) begin
        burst = $urandom_range(40, 4);
        case ($urandom_range(2))
          0: bias = 85;
          1: bias = 15;
          default: bias = 50;
        endcase
        for (k = 0; k < burst && made < RAND_PER_PHASE; k++) begin
          add_request(($urandom_range(99) < bias) ? REQ_INSERT : REQ_SEND,
                      class_t'($urandom_range(3)), $urandom(),
                      gap_by_phase[ph], stall_by_phase[ph], made == 0);
          made++;
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_outcomes.size() != 0)
      report_mismatch("responses never delivered", 64'(expected_outcomes.size()), '0);
    $display("covered %0d inserts, %0d sends, %0d empty sends, %0d dropped inserts",
             n_inserted, n_sent, n_empty, n_full);
    $display("peak occupancy %0d of %0d across four idle/stall phases, %0d mismatches",
             peak_occupancy, QUEUE_DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
